FILE: hw/rtl/setbl_pkg.sv
// ----------------------------------------------------------------------------
// setbl_pkg
// Shared codes and field widths for the sorted edge table.
// ----------------------------------------------------------------------------
package setbl_pkg;

    // port field widths
    localparam int unsigned VERTEX_W = 16;
    localparam int unsigned CAP_W    = 11;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned STATUS_W = 2;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOOKUP    = 2'd3;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

endpackage

FILE: hw/rtl/setbl_ram.sv
// ----------------------------------------------------------------------------
// setbl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module setbl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sorted_edge_table_top.sv
// ----------------------------------------------------------------------------
// sorted_edge_table_top
// Sorted table of mesh edges keyed by ordered vertex pair, insert and lookup.
// ----------------------------------------------------------------------------
// s_axis takes one request word: tuser is the action (0 insert, 1 lookup),
// tdata the two vertex numbers and the two facet numbers. m_axis returns one
// result word per request: tuser is the status, tdata position, match and the
// entry count after the request. i_cfg_we / i_cfg_wdata write the capacity;
// the user must write it only while no request is in flight; the block has no check for it.
// Each binary search step reads the middle entry, then compares on the
// registered data; there are at most ceil(log2(n+1)) steps over n entries.
// A fresh insert then moves each later entry up one place at one per cycle
// and writes the new entry into the freed place; a lookup, a duplicate and
// an insert into a full table write no entry. A new request is taken from
// the cycle after the result word is loaded, even while that word waits.
// Reset clears the entry count and sets capacity to 1024; the memories are
// not cleared since entries are read only below the count. A stalled receiver
// holds the result word, and a later finished request waits behind it.
// ----------------------------------------------------------------------------
module sorted_edge_table_top #(
    parameter int unsigned MAX_EDGES  = 1024,
    parameter int unsigned INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // capacity register
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // vertex_a, vertex_b, facet_a, facet_b
    input  logic [0:0]  s_axis_tuser,   // action

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // position, match, entry_count, zero pad
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int unsigned KW = 2 * INDEX_BITS;
    localparam int unsigned AW = $clog2(MAX_EDGES);
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned VW = setbl_pkg::VERTEX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                       r_state;
    logic [setbl_pkg::CAP_W-1:0]      r_capacity;
    logic [CW-1:0]                    r_count;
    logic                             r_action;
    logic [KW-1:0]                    r_key;
    logic [KW-1:0]                    r_facet;
    logic [CW-1:0]                    r_first;
    logic [CW-1:0]                    r_last;
    logic [CW-1:0]                    r_mid;
    logic                             r_eq;
    logic [setbl_pkg::STATUS_W-1:0]   r_status;
    logic [CW-1:0]                    r_idx;
    logic [AW-1:0]                    r_wa;
    logic                             r_pend;

    logic                             r_m_valid;
    logic [setbl_pkg::POS_W-1:0]      r_m_pos;
    logic                             r_m_match;
    logic [setbl_pkg::POS_W-1:0]      r_m_count;
    logic [setbl_pkg::STATUS_W-1:0]   r_m_status;

    // ordered pairs from the request word
    logic [INDEX_BITS-1:0] va, vb, fa, fb;
    logic [KW-1:0]         in_key, in_facet;
    logic [31:0]           ext_va, ext_vb, ext_fa, ext_fb;

    assign ext_va = {{(32-VW){1'b0}}, s_axis_tdata[VW-1:0]};
    assign ext_vb = {{(32-VW){1'b0}}, s_axis_tdata[2*VW-1:VW]};
    assign ext_fa = {{(32-VW){1'b0}}, s_axis_tdata[3*VW-1:2*VW]};
    assign ext_fb = {{(32-VW){1'b0}}, s_axis_tdata[4*VW-1:3*VW]};
    assign va = ext_va[INDEX_BITS-1:0];
    assign vb = ext_vb[INDEX_BITS-1:0];
    assign fa = ext_fa[INDEX_BITS-1:0];
    assign fb = ext_fb[INDEX_BITS-1:0];
    assign in_key   = (va > vb) ? {vb, va} : {va, vb};
    assign in_facet = (fa > fb) ? {fb, fa} : {fa, fb};

    // full check against capacity saturated at the table depth
    logic [31:0] cap_eff;
    logic        is_full;
    assign cap_eff = (32'(r_capacity) > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : 32'(r_capacity);
    assign is_full = 32'(r_count) >= cap_eff;

    logic          in_accept;
    logic [CW-1:0] mid;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign mid           = r_first + ((r_last - r_first) >> 1);

    // result register loads when done and the last word is gone or leaving
    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    // memory ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [KW-1:0] ram_wkey, ram_wfacet, key_rdata, facet_rdata;
    logic [CW-1:0] idx_dec;
    assign idx_dec = r_idx - CW'(1);

    always_comb begin
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_wa;
        ram_raddr  = mid[AW-1:0];
        ram_wkey   = key_rdata;
        ram_wfacet = facet_rdata;
        case (r_state)
            S_SRCH: begin
                ram_re = (r_first < r_last);
            end
            S_SHIFT: begin
                if (r_idx > r_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[AW-1:0];
                end
                if (r_pend) begin
                    ram_we = 1'b1;
                end else if (r_idx == r_last) begin
                    // all later entries moved, drop the new one in
                    ram_we     = 1'b1;
                    ram_waddr  = r_last[AW-1:0];
                    ram_wkey   = r_key;
                    ram_wfacet = r_facet;
                end
            end
            default: begin
            end
        endcase
    end

    setbl_ram #(.WIDTH(KW), .DEPTH(MAX_EDGES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wkey),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (key_rdata)
    );

    setbl_ram #(.WIDTH(KW), .DEPTH(MAX_EDGES)) u_facet_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wfacet),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (facet_rdata)
    );

    logic [31:0] last_ext, count_ext;
    assign last_ext  = 32'(r_last);
    assign count_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_capacity <= setbl_pkg::CAP_RESET;
            r_count    <= '0;
            r_m_valid  <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_action <= s_axis_tuser[0];
                        r_key    <= in_key;
                        r_facet  <= in_facet;
                        r_first  <= '0;
                        r_eq     <= 1'b0;
                        if (s_axis_tuser[0] == setbl_pkg::ACT_LOOKUP) begin
                            r_status <= setbl_pkg::ST_LOOKUP;
                            r_last   <= r_count;
                            r_state  <= S_SRCH;
                        end else if (is_full) begin
                            r_status <= setbl_pkg::ST_FULL;
                            r_last   <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_last  <= r_count;
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_first < r_last) begin
                        r_mid   <= mid;
                        r_state <= S_CMP;
                    end else if (r_action == setbl_pkg::ACT_LOOKUP) begin
                        r_state <= S_DONE;
                    end else if (r_eq) begin
                        r_status <= setbl_pkg::ST_DUPLICATE;
                        r_state  <= S_DONE;
                    end else begin
                        r_status <= setbl_pkg::ST_INSERTED;
                        r_idx    <= r_count;
                        r_pend   <= 1'b0;
                        r_state  <= S_SHIFT;
                    end
                end
                S_CMP: begin
                    // equality tracks the entry at the current upper bound
                    if (r_key <= key_rdata) begin
                        r_last <= r_mid;
                        r_eq   <= (r_key == key_rdata);
                    end else begin
                        r_first <= r_mid + CW'(1);
                    end
                    r_state <= S_SRCH;
                end
                S_SHIFT: begin
                    if (r_idx > r_last) begin
                        r_wa   <= r_idx[AW-1:0];
                        r_idx  <= idx_dec;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_m_pos    <= last_ext[setbl_pkg::POS_W-1:0];
                        r_m_match  <= r_eq;
                        r_m_count  <= count_ext[setbl_pkg::POS_W-1:0];
                        r_m_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_count, r_m_match, r_m_pos};
    assign m_axis_tuser  = r_m_status;

endmodule
